FILE: hdl/ostt_pkg.sv
`timescale 1ns / 1ps
// ostt_pkg: types, codes and defaults shared by the one-shot timer table
// depends on nothing; used by every module of the block

package ostt_pkg;

    localparam int NUM_SLOTS_DEF   = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int HANDLE_W = 16;
    localparam int WORD_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_ADD,
        CMD_REMOVE,
        CMD_QUERY
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_REMOVE,
        KIND_QUERY,
        KIND_FIRED
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } state_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [HANDLE_W-1:0] handle;
        logic [WORD_W-1:0]   object;
        logic [WORD_W-1:0]   delay;
    } command_t;

    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic                ok;
        logic [HANDLE_W-1:0] fired_handle;
        logic [WORD_W-1:0]   fired_object;
        logic                last;
    } result_t;

    // write requests into the slot store
    typedef struct packed {
        logic wr_all;
        logic wr_delay;
        logic clr_valid;
    } store_op_t;

    // status from the shared compare / decrement unit
    typedef struct packed {
        logic occupied;
        logic match;
        logic expired;
    } unit_flags_t;

    function automatic kind_t reply_kind(input cmd_t cmd);
        kind_t k;
        case (cmd)
            CMD_ADD:    k = KIND_ADD;
            CMD_REMOVE: k = KIND_REMOVE;
            CMD_QUERY:  k = KIND_QUERY;
            default:    k = KIND_QUERY;
        endcase
        return k;
    endfunction

    function automatic result_t make_reply(input kind_t kind, input logic ok,
                                           input logic [SLOT_W-1:0] slot);
        result_t r;
        r.kind         = kind;
        r.slot         = slot;
        r.ok           = ok;
        r.fired_handle = '0;
        r.fired_object = '0;
        r.last         = 1'b1;
        return r;
    endfunction

    function automatic result_t make_fire(input logic [SLOT_W-1:0] slot,
                                          input logic [HANDLE_W-1:0] handle,
                                          input logic [WORD_W-1:0] object,
                                          input logic last);
        result_t r;
        r.kind         = KIND_FIRED;
        r.slot         = slot;
        r.ok           = 1'b1;
        r.fired_handle = handle;
        r.fired_object = object;
        r.last         = last;
        return r;
    endfunction

endpackage

FILE: hdl/one_shot_timer_table.sv
`timescale 1ns / 1ps
// one_shot_timer_table: top level, command sequencer over the slot store
// depends on ostt_pkg, ostt_store, ostt_unit
//
//  channel   signals                 handshake
//  -------   ---------------------   ------------------------------------
//  command   start, busy, command    taken when start is high, busy low
//  result    result_valid, result    shown for one cycle, always taken
//  config    cfg_we, cfg_data        written when cfg_we is high
//
// the sequencer walks the slots through one store read port and one shared
// compare / decrement unit, each slot read, then evaluated; tick walks the slots
// up to the table size, stopping early once none is occupied; add, remove and
// query stop at the first matching slot, else reply with a failure; a rejected
// add or a remove of handle zero answers the next cycle without raising busy
// reset clears the occupancy bits at once, so no clearing pass is needed
// results cannot be held off; the final word shows in the first cycle with busy low

module one_shot_timer_table #(
    parameter int NUM_SLOTS   = ostt_pkg::NUM_SLOTS_DEF,
    parameter int HANDLE_BITS = ostt_pkg::HANDLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ostt_pkg::command_t             command,
    output logic                           result_valid,
    output ostt_pkg::result_t              result,
    input  logic                           cfg_we,
    input  logic [ostt_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IW = $clog2(NUM_SLOTS + 1);

    ostt_pkg::state_t              state_reg, state_next;
    ostt_pkg::cmd_t                cmd_reg, cmd_next;
    logic [HANDLE_BITS-1:0]        key_reg, key_next;
    logic [ostt_pkg::WORD_W-1:0]   obj_reg, obj_next;
    logic [ostt_pkg::WORD_W-1:0]   dly_reg, dly_next;
    logic [IW-1:0]                 idx_reg, idx_next;
    logic [IW-1:0]                 count_reg, count_next;
    logic [ostt_pkg::CFG_W-1:0]    cfg_reg;
    logic                          pend_valid_reg, pend_valid_next;
    logic [ostt_pkg::SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic [ostt_pkg::HANDLE_W-1:0] pend_handle_reg, pend_handle_next;
    logic [ostt_pkg::WORD_W-1:0]   pend_object_reg, pend_object_next;
    logic                          result_valid_reg, result_valid_next;
    ostt_pkg::result_t             result_reg, result_next;

    logic [IW-1:0]                 lim;
    logic [HANDLE_BITS-1:0]        key_in;
    logic [HANDLE_BITS-1:0]        search_key;
    logic                          reject_now;
    logic                          walk_end;
    logic [ostt_pkg::SLOT_W-1:0]   cur_slot;

    ostt_pkg::store_op_t           op;
    logic [ostt_pkg::WORD_W-1:0]   wr_delay;
    logic                          rd_valid;
    logic [HANDLE_BITS-1:0]        rd_handle;
    logic [ostt_pkg::WORD_W-1:0]   rd_delay;
    logic [ostt_pkg::WORD_W-1:0]   rd_object;
    ostt_pkg::unit_flags_t         flags;
    logic [ostt_pkg::WORD_W-1:0]   delay_dec;

    // register above the table size acts as the table size
    assign lim = (32'(cfg_reg) > 32'(NUM_SLOTS)) ? IW'(NUM_SLOTS) : IW'(cfg_reg);

    assign key_in   = HANDLE_BITS'(command.handle);
    assign cur_slot = ostt_pkg::SLOT_W'(idx_reg);

    // add looks for the first free slot, which reads as handle zero
    assign search_key = (cmd_reg == ostt_pkg::CMD_ADD) ? '0 : key_reg;

    assign reject_now =
        ((command.cmd == ostt_pkg::CMD_ADD) &&
         !((count_reg < lim) && (command.delay != '0) && (key_in != '0))) ||
        ((command.cmd == ostt_pkg::CMD_REMOVE) && (key_in == '0));

    // tick stops early once no slot is occupied
    assign walk_end = (idx_reg == lim) ||
                      ((cmd_reg == ostt_pkg::CMD_TICK) && (count_reg == '0));

    assign wr_delay = op.wr_all ? dly_reg : delay_dec;

    ostt_store #(
        .NUM_SLOTS   (NUM_SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .addr      (idx_reg[AW-1:0]),
        .op        (op),
        .wr_handle (key_reg),
        .wr_delay  (wr_delay),
        .wr_object (obj_reg),
        .rd_valid  (rd_valid),
        .rd_handle (rd_handle),
        .rd_delay  (rd_delay),
        .rd_object (rd_object)
    );

    ostt_unit #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_unit (
        .rd_valid  (rd_valid),
        .rd_handle (rd_handle),
        .key       (search_key),
        .rd_delay  (rd_delay),
        .flags     (flags),
        .delay_dec (delay_dec)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ostt_pkg::S_IDLE:
            begin
                if (start && !reject_now)
                begin
                    state_next = ostt_pkg::S_READ;
                end
            end
            ostt_pkg::S_READ:
            begin
                state_next = walk_end ? ostt_pkg::S_IDLE : ostt_pkg::S_EVAL;
            end
            ostt_pkg::S_EVAL:
            begin
                if ((cmd_reg != ostt_pkg::CMD_TICK) && flags.match)
                begin
                    state_next = ostt_pkg::S_IDLE;
                end
                else
                begin
                    state_next = ostt_pkg::S_READ;
                end
            end
            default:
            begin
                state_next = ostt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next          = cmd_reg;
        key_next          = key_reg;
        obj_next          = obj_reg;
        dly_next          = dly_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        pend_handle_next  = pend_handle_reg;
        pend_object_next  = pend_object_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        op                = '0;

        case (state_reg)
            ostt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = command.cmd;
                    key_next        = key_in;
                    obj_next        = command.object;
                    dly_next        = command.delay;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    if (reject_now)
                    begin
                        result_valid_next = 1'b1;
                        result_next = ostt_pkg::make_reply(
                            ostt_pkg::reply_kind(command.cmd), 1'b0, '0);
                    end
                end
            end
            ostt_pkg::S_READ:
            begin
                if (walk_end)
                begin
                    if (cmd_reg == ostt_pkg::CMD_TICK)
                    begin
                        // the held fired word is the last of this tick
                        if (pend_valid_reg)
                        begin
                            result_valid_next = 1'b1;
                            result_next = ostt_pkg::make_fire(pend_slot_reg,
                                pend_handle_reg, pend_object_reg, 1'b1);
                        end
                        pend_valid_next = 1'b0;
                    end
                    else
                    begin
                        result_valid_next = 1'b1;
                        result_next = ostt_pkg::make_reply(
                            ostt_pkg::reply_kind(cmd_reg), 1'b0, '0);
                    end
                end
            end
            ostt_pkg::S_EVAL:
            begin
                if (cmd_reg == ostt_pkg::CMD_TICK)
                begin
                    idx_next = IW'(idx_reg + IW'(1));
                    if (flags.occupied)
                    begin
                        if (flags.expired)
                        begin
                            op.clr_valid = 1'b1;
                            count_next   = count_reg - IW'(1);
                            if (pend_valid_reg)
                            begin
                                result_valid_next = 1'b1;
                                result_next = ostt_pkg::make_fire(pend_slot_reg,
                                    pend_handle_reg, pend_object_reg, 1'b0);
                            end
                            pend_valid_next  = 1'b1;
                            pend_slot_next   = cur_slot;
                            pend_handle_next = ostt_pkg::HANDLE_W'(rd_handle);
                            pend_object_next = rd_object;
                        end
                        else
                        begin
                            op.wr_delay = 1'b1;
                        end
                    end
                end
                else if (flags.match)
                begin
                    result_valid_next = 1'b1;
                    result_next = ostt_pkg::make_reply(
                        ostt_pkg::reply_kind(cmd_reg), 1'b1, cur_slot);
                    case (cmd_reg)
                        ostt_pkg::CMD_ADD:
                        begin
                            op.wr_all  = 1'b1;
                            count_next = IW'(count_reg + IW'(1));
                        end
                        ostt_pkg::CMD_REMOVE:
                        begin
                            op.clr_valid = 1'b1;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - IW'(1);
                            end
                        end
                        default:
                        begin
                            op = '0;
                        end
                    endcase
                end
                else
                begin
                    idx_next = IW'(idx_reg + IW'(1));
                end
            end
            default:
            begin
                op = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ostt_pkg::S_IDLE;
            count_reg        <= '0;
            cfg_reg          <= ostt_pkg::CFG_RESET;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            idx_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
            idx_reg          <= idx_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        obj_reg         <= obj_next;
        dly_reg         <= dly_next;
        pend_slot_reg   <= pend_slot_next;
        pend_handle_reg <= pend_handle_next;
        pend_object_reg <= pend_object_next;
        result_reg      <= result_next;
    end

    assign busy         = (state_reg != ostt_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: hdl/ostt_store.sv
`timescale 1ns / 1ps
// ostt_store: slot memories for handle, delay and object, plus occupancy bits
// depends on ostt_pkg

module ostt_store #(
    parameter int NUM_SLOTS   = ostt_pkg::NUM_SLOTS_DEF,
    parameter int HANDLE_BITS = ostt_pkg::HANDLE_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] addr,
    input  ostt_pkg::store_op_t                      op,
    input  logic [HANDLE_BITS-1:0]                   wr_handle,
    input  logic [ostt_pkg::WORD_W-1:0]              wr_delay,
    input  logic [ostt_pkg::WORD_W-1:0]              wr_object,
    output logic                                     rd_valid,
    output logic [HANDLE_BITS-1:0]                   rd_handle,
    output logic [ostt_pkg::WORD_W-1:0]              rd_delay,
    output logic [ostt_pkg::WORD_W-1:0]              rd_object
);

    logic [HANDLE_BITS-1:0]      handle_mem [NUM_SLOTS];
    logic [ostt_pkg::WORD_W-1:0] delay_mem  [NUM_SLOTS];
    logic [ostt_pkg::WORD_W-1:0] object_mem [NUM_SLOTS];

    logic [NUM_SLOTS-1:0]        valid_reg;
    logic                        rd_valid_reg;
    logic [HANDLE_BITS-1:0]      rd_handle_reg;
    logic [ostt_pkg::WORD_W-1:0] rd_delay_reg;
    logic [ostt_pkg::WORD_W-1:0] rd_object_reg;

    // occupancy: cleared at reset, so memory contents need no clearing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (op.wr_all)
            begin
                valid_reg[addr] <= 1'b1;
            end
            else if (op.clr_valid)
            begin
                valid_reg[addr] <= 1'b0;
            end
            rd_valid_reg <= valid_reg[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.wr_all)
        begin
            handle_mem[addr] <= wr_handle;
            object_mem[addr] <= wr_object;
        end
        if (op.wr_all || op.wr_delay)
        begin
            delay_mem[addr] <= wr_delay;
        end
        rd_handle_reg <= handle_mem[addr];
        rd_delay_reg  <= delay_mem[addr];
        rd_object_reg <= object_mem[addr];
    end

    assign rd_valid  = rd_valid_reg;
    assign rd_handle = rd_handle_reg;
    assign rd_delay  = rd_delay_reg;
    assign rd_object = rd_object_reg;

endmodule

FILE: hdl/ostt_unit.sv
`timescale 1ns / 1ps
// ostt_unit: shared compare and decrement unit applied to one slot per step
// depends on ostt_pkg

module ostt_unit #(
    parameter int HANDLE_BITS = ostt_pkg::HANDLE_BITS_DEF
) (
    input  logic                        rd_valid,
    input  logic [HANDLE_BITS-1:0]      rd_handle,
    input  logic [HANDLE_BITS-1:0]      key,
    input  logic [ostt_pkg::WORD_W-1:0] rd_delay,
    output ostt_pkg::unit_flags_t       flags,
    output logic [ostt_pkg::WORD_W-1:0] delay_dec
);

    logic [HANDLE_BITS-1:0] eff_handle;

    // a free slot reads as handle zero
    assign eff_handle     = rd_valid ? rd_handle : '0;
    assign flags.occupied = rd_valid;
    assign flags.match    = (eff_handle == key);
    assign flags.expired  = (rd_delay == '0);
    assign delay_dec      = rd_delay - ostt_pkg::WORD_W'(1);

endmodule
